@@ rtl/core/ldcq_pkg.sv @@
// ----------------------------------------------------------------------------
// ldcq_pkg
// shared types, constants and helpers of the lossy delay channel queue
// ----------------------------------------------------------------------------
package ldcq_pkg;

   localparam int QueueDepth  = 32;
   localparam int HeaderBits  = 928;
   localparam int MaxResults  = 32;
   localparam int PtrWidth    = $clog2(QueueDepth);
   localparam int CountWidth  = $clog2(QueueDepth + 1);
   localparam int NumWidth    = $clog2(MaxResults + 1);
   localparam int TimeWidth   = 40;
   localparam int DvdWidth    = 16;
   localparam int MsToUs      = 1000;

   localparam logic [2:0] StatusQueued    = 3'd0;
   localparam logic [2:0] StatusLost      = 3'd1;
   localparam logic [2:0] StatusFull      = 3'd2;
   localparam logic [2:0] StatusDelivered = 3'd3;
   localparam logic [2:0] StatusNoneDue   = 3'd4;

   localparam logic OpArrive = 1'b0;
   localparam logic OpCheck  = 1'b1;

   localparam logic [1:0] RegRate   = 2'd0;
   localparam logic [1:0] RegLoss   = 2'd1;
   localparam logic [1:0] RegJitter = 2'd2;

   typedef struct packed {
      logic        op;
      logic [15:0] message_handle;
      logic [11:0] message_bytes;
      logic [39:0] now_us;
      logic [6:0]  loss_draw;
      logic [14:0] jitter_draw;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_handle;
      logic [39:0] arrive_time_us;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [13:0] rate_mbps;
      logic [6:0]  loss_percent;
      logic [9:0]  jitter_span_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_CHECK,
      CMD_LOST,
      CMD_ARRIVE
   } cmd_kind_type;

   // time holds now for a check, arrival time for an arrival
   typedef struct packed {
      cmd_kind_type          kind;
      logic [15:0]           handle;
      logic [TimeWidth-1:0]  time_us;
   } cmd_type;

   typedef struct packed {
      logic [TimeWidth-1:0] time_us;
      logic [15:0]          handle;
   } entry_type;

   // circular index: sum of two values each below the depth
   function automatic logic [PtrWidth-1:0] wrap_idx(input logic [CountWidth:0] sum);
      logic [CountWidth:0] red;
      begin
         red = sum;
         if (sum >= (CountWidth+1)'(QueueDepth)) begin
            red = sum - (CountWidth+1)'(QueueDepth);
         end
         return red[PtrWidth-1:0];
      end
   endfunction

endpackage

@@ rtl/core/ldcq_fifo.sv @@
// ----------------------------------------------------------------------------
// ldcq_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module ldcq_fifo
   import ldcq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop && not_empty) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_ff + 2'(push && !full) - 2'(pop && not_empty);
      end
   end

endmodule

@@ rtl/core/ldcq_front.sv @@
// ----------------------------------------------------------------------------
// ldcq_front
// accepts words, decides loss and computes arrival time with a serial divider
// ----------------------------------------------------------------------------
module ldcq_front
   import ldcq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         push,
   output cmd_type      push_cmd,
   input  logic         fifo_full
);

   typedef enum logic [2:0] {
      F_IDLE,
      F_DIV,
      F_MOD,
      F_MUL,
      F_SUM1,
      F_SUM2,
      F_PUSH
   } fstate_type;

   fstate_type           state_ff;
   req_word_type         word_ff;
   cmd_type              cmd_ff;
   logic [3:0]           step_ff;
   logic [DvdWidth-1:0]  dvd_ff;
   logic [13:0]          rem_ff;
   logic [13:0]          divisor_ff;
   logic [DvdWidth-1:0]  quo_ff;
   logic [19:0]          jit_us_ff;
   logic [TimeWidth:0]   sum_ff;

   logic [14:0]          rem_sh;
   logic                 fits;
   logic [14:0]          rem_in;
   logic [TimeWidth+1:0] sum2;

   assign rem_sh     = {rem_ff, dvd_ff[DvdWidth-1]};
   assign fits       = (rem_sh >= {1'b0, divisor_ff});
   assign rem_in     = fits ? (rem_sh - {1'b0, divisor_ff}) : rem_sh;
   assign sum2       = {1'b0, sum_ff} + (TimeWidth+2)'(jit_us_ff);

   assign req_stall = (state_ff != F_IDLE);
   assign push      = (state_ff == F_PUSH);
   assign push_cmd  = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  word_ff        <= req_data;
                  cmd_ff.handle  <= req_data.message_handle;
                  cmd_ff.time_us <= req_data.now_us;
                  if (req_data.op == OpCheck) begin
                     cmd_ff.kind <= CMD_CHECK;
                     state_ff    <= F_PUSH;
                  end else if (req_data.loss_draw < cfg.loss_percent) begin
                     cmd_ff.kind <= CMD_LOST;
                     state_ff    <= F_PUSH;
                  end else begin
                     cmd_ff.kind <= CMD_ARRIVE;
                     dvd_ff      <= DvdWidth'({req_data.message_bytes, 3'b000})
                                    + DvdWidth'(HeaderBits);
                     rem_ff      <= '0;
                     step_ff     <= '0;
                     divisor_ff  <= (cfg.rate_mbps == '0) ? 14'd1 : cfg.rate_mbps;
                     state_ff    <= F_DIV;
                  end
               end
            end
            F_DIV: begin
               // one quotient bit per cycle, quotient shifts in from the bottom
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'hF) begin
                  quo_ff     <= {dvd_ff[DvdWidth-2:0], fits};
                  dvd_ff     <= DvdWidth'(word_ff.jitter_draw);
                  rem_ff     <= '0;
                  divisor_ff <= 14'(cfg.jitter_span_ms);
                  if (cfg.jitter_span_ms == '0) begin
                     jit_us_ff <= '0;
                     state_ff  <= F_SUM1;
                  end else begin
                     state_ff  <= F_MOD;
                  end
               end else begin
                  rem_ff <= rem_in[13:0];
                  dvd_ff <= {dvd_ff[DvdWidth-2:0], fits};
               end
            end
            F_MOD: begin
               rem_ff  <= rem_in[13:0];
               dvd_ff  <= {dvd_ff[DvdWidth-2:0], fits};
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'hF) begin
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               jit_us_ff <= 20'(rem_ff[9:0]) * 20'(MsToUs);
               state_ff  <= F_SUM1;
            end
            F_SUM1: begin
               sum_ff   <= {1'b0, word_ff.now_us} + (TimeWidth+1)'(quo_ff);
               state_ff <= F_SUM2;
            end
            F_SUM2: begin
               // saturate at the top of the time range
               if (sum2[TimeWidth+1:TimeWidth] != 2'b00) begin
                  cmd_ff.time_us <= '1;
               end else begin
                  cmd_ff.time_us <= sum2[TimeWidth-1:0];
               end
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!fifo_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/core/ldcq_back.sv @@
// ----------------------------------------------------------------------------
// ldcq_back
// sorted circular queue: insertion walk, release of due words, result register
// ----------------------------------------------------------------------------
module ldcq_back
   import ldcq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   typedef enum logic [2:0] {
      B_IDLE,
      B_INS_RD,
      B_INS_CMP,
      B_INS_WR,
      B_REL_RD,
      B_REL_CMP,
      B_EMIT
   } bstate_type;

   bstate_type            state_ff;
   cmd_type               cmd_ff;
   logic [PtrWidth-1:0]   head_ff;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] pos_ff;
   logic [NumWidth-1:0]   num_ff;
   logic                  have_cand_ff;
   entry_type             cand_ff;
   rsp_word_type          res_ff;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_data_ff;

   entry_type             mem [QueueDepth];
   entry_type             rdata_ff;

   logic                  out_free;
   logic                  emit_now;
   logic [PtrWidth-1:0]   raddr;
   logic                  we;
   logic [PtrWidth-1:0]   waddr;
   entry_type             wdata;
   logic                  later;
   logic                  due;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cmd_pop   = (state_ff == B_IDLE) && cmd_valid;
   assign later     = (rdata_ff.time_us > cmd_ff.time_us);
   assign due       = !later;
   // a word is written into the output register this cycle
   assign emit_now  = out_free && ((state_ff == B_EMIT) ||
                      (state_ff == B_REL_CMP && (have_cand_ff || !due)));

   always_comb begin
      raddr = head_ff;
      if (state_ff == B_INS_RD) begin
         raddr = wrap_idx((CountWidth+1)'(head_ff) + (CountWidth+1)'(pos_ff - 1'b1));
      end
   end

   always_comb begin
      we    = 1'b0;
      waddr = wrap_idx((CountWidth+1)'(head_ff) + (CountWidth+1)'(pos_ff));
      wdata = rdata_ff;
      if (state_ff == B_INS_CMP && later) begin
         we = 1'b1;
      end else if (state_ff == B_INS_WR) begin
         we    = 1'b1;
         wdata = '{time_us: cmd_ff.time_us, handle: cmd_ff.handle};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         have_cand_ff <= 1'b0;
      end else begin
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd;
                  case (cmd.kind)
                     CMD_LOST: begin
                        res_ff   <= '{StatusLost, cmd.handle, '0, 1'b1};
                        state_ff <= B_EMIT;
                     end
                     CMD_ARRIVE: begin
                        pos_ff <= count_ff;
                        if (count_ff == CountWidth'(QueueDepth)) begin
                           res_ff   <= '{StatusFull, cmd.handle, cmd.time_us, 1'b1};
                           state_ff <= B_EMIT;
                        end else if (count_ff == '0) begin
                           state_ff <= B_INS_WR;
                        end else begin
                           state_ff <= B_INS_RD;
                        end
                     end
                     default: begin
                        num_ff       <= '0;
                        have_cand_ff <= 1'b0;
                        if (count_ff == '0) begin
                           res_ff   <= '{StatusNoneDue, '0, '0, 1'b1};
                           state_ff <= B_EMIT;
                        end else begin
                           state_ff <= B_REL_RD;
                        end
                     end
                  endcase
               end
            end
            B_INS_RD: state_ff <= B_INS_CMP;
            B_INS_CMP: begin
               // later entries move one place up, equal times stay ahead
               if (later) begin
                  pos_ff   <= pos_ff - 1'b1;
                  state_ff <= (pos_ff == CountWidth'(1)) ? B_INS_WR : B_INS_RD;
               end else begin
                  state_ff <= B_INS_WR;
               end
            end
            B_INS_WR: begin
               count_ff <= count_ff + 1'b1;
               res_ff   <= '{StatusQueued, cmd_ff.handle, cmd_ff.time_us, 1'b1};
               state_ff <= B_EMIT;
            end
            B_REL_RD: state_ff <= B_REL_CMP;
            B_REL_CMP: begin
               if (out_free) begin
                  if (due) begin
                     if (have_cand_ff) begin
                        rsp_data_ff  <= '{StatusDelivered, cand_ff.handle,
                                          cand_ff.time_us, 1'b0};
                     end
                     cand_ff      <= rdata_ff;
                     have_cand_ff <= 1'b1;
                     head_ff      <= wrap_idx((CountWidth+1)'(head_ff) + (CountWidth+1)'(1));
                     count_ff     <= count_ff - 1'b1;
                     num_ff       <= num_ff + 1'b1;
                     if (count_ff == CountWidth'(1) ||
                         num_ff == NumWidth'(MaxResults - 1)) begin
                        res_ff   <= '{StatusDelivered, rdata_ff.handle,
                                      rdata_ff.time_us, 1'b1};
                        state_ff <= B_EMIT;
                     end else begin
                        state_ff <= B_REL_RD;
                     end
                  end else begin
                     if (have_cand_ff) begin
                        rsp_data_ff <= '{StatusDelivered, cand_ff.handle,
                                         cand_ff.time_us, 1'b1};
                     end else begin
                        rsp_data_ff <= '{StatusNoneDue, '0, '0, 1'b1};
                     end
                     state_ff <= B_IDLE;
                  end
               end
            end
            B_EMIT: begin
               if (out_free) begin
                  rsp_data_ff  <= res_ff;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/core/lossy_delay_channel_queue.sv @@
// ----------------------------------------------------------------------------
// lossy_delay_channel_queue
// lossy, delaying link model with an arrival-time ordered delivery queue
// ----------------------------------------------------------------------------
// steps: an arrival passes the front in two 16-step serial divides, one multiply
//   and two adds (second divide and multiply skipped at zero jitter span); a check
//   goes straight to the push; the back reads and compares each queued word moved
//   by an insert and each released word; the front takes a new word only once the
//   last is pushed, both divides share one serial divider; the queue holds 2
// reset: synchronous, clears the delivery queue count and handshake state
// ----------------------------------------------------------------------------
module lossy_delay_channel_queue
   import ldcq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input words
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   // result words
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // link settings
   cfg_type    cfg_ff;
   logic [1:0] reg_idx;

   // front to back command queue
   logic    push;
   cmd_type push_cmd;
   logic    fifo_full;
   logic    pop;
   logic    fifo_not_empty;
   cmd_type head_cmd;

   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   // register writes land on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_mbps      <= 14'd54;
         cfg_ff.loss_percent   <= '0;
         cfg_ff.jitter_span_ms <= 10'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            RegRate:   cfg_ff.rate_mbps      <= csr_pwdata[13:0];
            RegLoss:   cfg_ff.loss_percent   <= csr_pwdata[6:0];
            RegJitter: cfg_ff.jitter_span_ms <= csr_pwdata[9:0];
            default:   ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (reg_idx)
         RegRate:   csr_prdata = 32'(cfg_ff.rate_mbps);
         RegLoss:   csr_prdata = 32'(cfg_ff.loss_percent);
         RegJitter: csr_prdata = 32'(cfg_ff.jitter_span_ms);
         default:   csr_prdata = '0;
      endcase
   end

   // front: loss decision and arrival time
   ldcq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_cmd  (push_cmd),
      .fifo_full (fifo_full)
   );

   // decouples the divider from the queue walk
   ldcq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (fifo_full),
      .pop       (pop),
      .not_empty (fifo_not_empty),
      .head_cmd  (head_cmd)
   );

   // back: sorted insert, release of due words, result register
   ldcq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (fifo_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
